/* src/lstp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lstp_pkg: shared definitions of the laser scan to points block
// Sizes, register and result codes, sequencer state codes, the CORDIC
// arctangent table and the request/response bundles of the rotation unit.
// ----------------------------------------------------------------------------
package lstp_pkg;

  // scan and rotation sizes
  localparam int unsigned MAX_SAMPLES  = 4096;
  localparam int unsigned IDX_W        = $clog2(MAX_SAMPLES);
  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned STEP_W       = $clog2(CORDIC_STEPS);

  // datapath widths
  localparam int unsigned ANG_W  = 32;
  localparam int unsigned RNG_W  = 16;
  localparam int unsigned OUT_W  = 17;
  localparam int unsigned ACC_W  = 35;
  localparam int unsigned Z_W    = 34;
  localparam int unsigned ATAN_W = 30;
  localparam int unsigned GAIN_W = 30;
  localparam int unsigned FRAC_W = 16;

  // cordic gain 0.6072529350 in Q30
  localparam logic [GAIN_W-1:0] GAIN_Q30 = 30'd652032875;
  localparam logic signed [OUT_W-1:0] OUT_LIMIT = 17'sd65535;

  // configuration register indexes
  localparam logic [1:0] CFG_START_ANGLE = 2'd0;
  localparam logic [1:0] CFG_ANGLE_STEP  = 2'd1;
  localparam logic [1:0] CFG_RANGE_MIN   = 2'd2;
  localparam logic [1:0] CFG_RANGE_MAX   = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_HIT  = 2'd0;
  localparam logic [1:0] KIND_MISS = 2'd1;
  localparam logic [1:0] KIND_DROP = 2'd2;

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ANGLE = 3'd1;
  localparam logic [2:0] ST_ROT1  = 3'd2;
  localparam logic [2:0] ST_ROT2  = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  typedef struct packed {
    logic             start;
    logic [RNG_W-1:0] mag;
    logic [ANG_W-1:0] ang;
  } rot_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
  } rot_rsp_t;

  // atan(2^-i) in binary angle units, rounded to nearest
  function automatic logic [ATAN_W-1:0] atan_f(input logic [4:0] i);
    logic [ATAN_W-1:0] a;
    unique case (i)
      5'd0:    a = 30'd536870912;
      5'd1:    a = 30'd316933406;
      5'd2:    a = 30'd167458907;
      5'd3:    a = 30'd85004756;
      5'd4:    a = 30'd42667331;
      5'd5:    a = 30'd21354465;
      5'd6:    a = 30'd10679838;
      5'd7:    a = 30'd5340245;
      5'd8:    a = 30'd2670163;
      5'd9:    a = 30'd1335087;
      5'd10:   a = 30'd667544;
      5'd11:   a = 30'd333772;
      5'd12:   a = 30'd166886;
      5'd13:   a = 30'd83443;
      5'd14:   a = 30'd41722;
      5'd15:   a = 30'd20861;
      5'd16:   a = 30'd10430;
      5'd17:   a = 30'd5215;
      5'd18:   a = 30'd2608;
      5'd19:   a = 30'd1304;
      5'd20:   a = 30'd652;
      5'd21:   a = 30'd326;
      5'd22:   a = 30'd163;
      5'd23:   a = 30'd81;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

/* src/laser_scan_to_points_gated.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// laser_scan_to_points_gated: laser range samples to gated Cartesian points
// Turns each range sample into x/y and classifies it as hit, miss or drop.
// ----------------------------------------------------------------------------
// One sample is in flight at a time. A valid sample goes from request to
// result through accept, angle multiply, CORDIC load, 16 rotation steps and
// result capture; a miss runs the rotation unit a second time for the point
// at range_max, and an invalid sample skips the rotation unit. A finished
// result sits in an output register, so the next request is taken while it
// waits.
module laser_scan_to_points_gated (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [1:0]               cfg_idx_i,
  input  wire logic [31:0]              cfg_wdata_i,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic                     scan_start_i,
  input  wire logic [15:0]              range_value_i,
  input  wire logic                     range_ok_i,
  input  wire logic [15:0]              intensity_in_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic signed [16:0]            point_x_o,
  output logic signed [16:0]            point_y_o,
  output logic [1:0]                    kind_o,
  output logic signed [16:0]            miss_x_o,
  output logic signed [16:0]            miss_y_o,
  output logic [15:0]                   intensity_out_o,
  output logic [11:0]                   sample_index_o
);

  localparam int unsigned IW = lstp_pkg::IDX_W;

  // configuration
  logic [31:0] start_angle_q, angle_step_q;
  logic [15:0] range_min_q, range_max_q;

  // sequencer and captured request
  logic [2:0]    state_q, state_d;
  logic [IW-1:0] cnt_q, cnt_d, idx_q, idx_d;
  logic [15:0]   r_q, inten_q;
  logic          ok_q;
  logic [31:0]   ang_q;
  logic          start_q, start_d;

  logic signed [16:0] px_q, py_q, mx_q, my_q;
  logic [1:0]         kind_q;

  logic [31+IW:0] step_prod;
  logic           accept, load_out;

  lstp_pkg::rot_req_t rot_req;
  lstp_pkg::rot_rsp_t rot_rsp;

  assign in_ready_o = (state_q == lstp_pkg::ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign load_out   = (state_q == lstp_pkg::ST_DONE) && (!out_valid_o || out_ready_i);

  assign idx_d = scan_start_i ? '0 : cnt_q;
  assign cnt_d = (idx_d == IW'(lstp_pkg::MAX_SAMPLES - 1)) ? '0 : idx_d + 1'b1;

  assign step_prod = angle_step_q * idx_q;

  assign rot_req.start = start_q;
  assign rot_req.mag   = (state_q == lstp_pkg::ST_ROT2) ? range_max_q : r_q;
  assign rot_req.ang   = ang_q;

  lstp_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rot_req),
    .rsp_o  (rot_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_angle_q <= '0;
      angle_step_q  <= '0;
      range_min_q   <= '0;
      range_max_q   <= 16'hFFFF;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lstp_pkg::CFG_START_ANGLE: start_angle_q <= cfg_wdata_i;
        lstp_pkg::CFG_ANGLE_STEP:  angle_step_q  <= cfg_wdata_i;
        lstp_pkg::CFG_RANGE_MIN:   range_min_q   <= cfg_wdata_i[15:0];
        lstp_pkg::CFG_RANGE_MAX:   range_max_q   <= cfg_wdata_i[15:0];
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    start_d = 1'b0;
    unique case (state_q)
      lstp_pkg::ST_IDLE: begin
        if (accept) state_d = lstp_pkg::ST_ANGLE;
      end
      lstp_pkg::ST_ANGLE: begin
        if (ok_q) begin
          state_d = lstp_pkg::ST_ROT1;
          start_d = 1'b1;
        end else begin
          state_d = lstp_pkg::ST_DONE;
        end
      end
      lstp_pkg::ST_ROT1: begin
        if (rot_rsp.done) begin
          if (r_q > range_max_q) begin
            state_d = lstp_pkg::ST_ROT2;
            start_d = 1'b1;
          end else begin
            state_d = lstp_pkg::ST_DONE;
          end
        end
      end
      lstp_pkg::ST_ROT2: begin
        if (rot_rsp.done) state_d = lstp_pkg::ST_DONE;
      end
      lstp_pkg::ST_DONE: begin
        if (load_out) state_d = lstp_pkg::ST_IDLE;
      end
      default: state_d = lstp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lstp_pkg::ST_IDLE;
      start_q     <= 1'b0;
      cnt_q       <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      start_q <= start_d;
      if (accept) cnt_q <= cnt_d;
      if (load_out) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // payload of the sample in flight
  always_ff @(posedge clk_i) begin
    if (accept) begin
      idx_q   <= idx_d;
      r_q     <= range_value_i;
      ok_q    <= range_ok_i;
      inten_q <= intensity_in_i;
    end
    if (state_q == lstp_pkg::ST_ANGLE) begin
      ang_q  <= start_angle_q + step_prod[31:0];
      px_q   <= '0;
      py_q   <= '0;
      mx_q   <= '0;
      my_q   <= '0;
      kind_q <= lstp_pkg::KIND_DROP;
    end
    if (state_q == lstp_pkg::ST_ROT1 && rot_rsp.done) begin
      px_q <= rot_rsp.x;
      py_q <= rot_rsp.y;
      if (r_q >= range_min_q && r_q <= range_max_q) begin
        kind_q <= lstp_pkg::KIND_HIT;
      end else if (r_q > range_max_q) begin
        kind_q <= lstp_pkg::KIND_MISS;
      end else begin
        kind_q <= lstp_pkg::KIND_DROP;
      end
    end
    if (state_q == lstp_pkg::ST_ROT2 && rot_rsp.done) begin
      mx_q <= rot_rsp.x;
      my_q <= rot_rsp.y;
    end
    if (load_out) begin
      point_x_o       <= px_q;
      point_y_o       <= py_q;
      kind_o          <= kind_q;
      miss_x_o        <= mx_q;
      miss_y_o        <= my_q;
      intensity_out_o <= inten_q;
      sample_index_o  <= 12'(idx_q);
    end
  end

endmodule
`default_nettype wire

/* src/lstp_cordic.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lstp_cordic: iterative CORDIC rotation unit
// Scales a range by the CORDIC gain, folds the angle into [-pi/2, pi/2) and
// runs one micro-rotation per cycle, then rounds and saturates the result.
// ----------------------------------------------------------------------------
module lstp_cordic (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire lstp_pkg::rot_req_t req_i,
  output lstp_pkg::rot_rsp_t      rsp_o
);

  logic signed [lstp_pkg::ACC_W-1:0] x_q, x_d, y_q, y_d;
  logic signed [lstp_pkg::Z_W-1:0]   z_q, z_d;
  logic [lstp_pkg::STEP_W-1:0]       step_q, step_d;
  logic                              run_q, run_d, done_q, done_d;

  logic [lstp_pkg::RNG_W+lstp_pkg::GAIN_W-1:0] gprod;
  logic [lstp_pkg::ANG_W-1:0]                  ang_sum, za;
  logic                                        fold;
  logic signed [lstp_pkg::ACC_W-1:0]           x_init, dx, dy;
  logic signed [lstp_pkg::Z_W-1:0]             atan_s;

  function automatic logic signed [lstp_pkg::OUT_W-1:0] round_sat(
    input logic signed [lstp_pkg::ACC_W-1:0] v
  );
    logic signed [lstp_pkg::ACC_W-1:0] t;
    logic signed [lstp_pkg::ACC_W-1:0] s;
    logic signed [lstp_pkg::OUT_W-1:0] r;
    t = v + lstp_pkg::ACC_W'(1 << (lstp_pkg::FRAC_W - 1));
    s = t >>> lstp_pkg::FRAC_W;
    if (s > lstp_pkg::ACC_W'(lstp_pkg::OUT_LIMIT)) begin
      r = lstp_pkg::OUT_LIMIT;
    end else if (s < -lstp_pkg::ACC_W'(lstp_pkg::OUT_LIMIT)) begin
      r = -lstp_pkg::OUT_LIMIT;
    end else begin
      r = s[lstp_pkg::OUT_W-1:0];
    end
    return r;
  endfunction

  // start vector: range times gain with 16 fraction bits
  assign gprod   = req_i.mag * lstp_pkg::GAIN_Q30;
  assign ang_sum = req_i.ang + 32'h4000_0000;
  assign fold    = ang_sum[lstp_pkg::ANG_W-1];
  assign za      = fold ? (req_i.ang - 32'h8000_0000) : req_i.ang;
  assign x_init  = $signed({3'b000, gprod[lstp_pkg::RNG_W+lstp_pkg::GAIN_W-1:14]});

  assign dx     = y_q >>> step_q;
  assign dy     = x_q >>> step_q;
  assign atan_s = $signed(lstp_pkg::Z_W'(lstp_pkg::atan_f(5'(step_q))));

  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    step_d = step_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (req_i.start) begin
      x_d    = fold ? -x_init : x_init;
      y_d    = '0;
      z_d    = lstp_pkg::Z_W'($signed(za));
      step_d = '0;
      run_d  = 1'b1;
    end else if (run_q) begin
      if (z_q >= 0) begin
        x_d = x_q - dx;
        y_d = y_q + dy;
        z_d = z_q - atan_s;
      end else begin
        x_d = x_q + dx;
        y_d = y_q - dy;
        z_d = z_q + atan_s;
      end
      step_d = step_q + 1'b1;
      if (step_q == lstp_pkg::STEP_W'(lstp_pkg::CORDIC_STEPS - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.x    = round_sat(x_q);
  assign rsp_o.y    = round_sat(y_q);

endmodule
`default_nettype wire

/* src/lstp_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lstp_checker: port-level checks of the laser scan to points block
// Watches the handshakes and result fields of the top level over time.
// ----------------------------------------------------------------------------
module lstp_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire logic signed [16:0] point_x_o,
  input wire logic signed [16:0] point_y_o,
  input wire logic [1:0]         kind_o,
  input wire logic signed [16:0] miss_x_o,
  input wire logic signed [16:0] miss_y_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o) && $stable(point_x_o))
    else $error("stalled result changed");

  // one request at a time
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready right after a request");

  a_kind_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (kind_o == lstp_pkg::KIND_HIT || kind_o == lstp_pkg::KIND_MISS ||
                     kind_o == lstp_pkg::KIND_DROP))
    else $error("unknown result kind");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != lstp_pkg::KIND_MISS |-> miss_x_o == '0 && miss_y_o == '0)
    else $error("miss point set on a non-miss");

  // saturation keeps the points off the most negative code
  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> point_x_o != -17'sd65536 && point_y_o != -17'sd65536)
    else $error("point outside saturation range");

endmodule

bind laser_scan_to_points_gated lstp_checker u_lstp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .point_x_o   (point_x_o),
  .point_y_o   (point_y_o),
  .kind_o      (kind_o),
  .miss_x_o    (miss_x_o),
  .miss_y_o    (miss_y_o)
);
`default_nettype wire
